// ----- hw/rtl/pbr_pkg.sv -----
// types and constants shared by the packbits row encoder
package pbr_pkg;

  localparam int BYTE_W = 8;
  localparam logic [8:0] REP_BASE = 9'd257;

  typedef struct packed {
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic              row_end;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_first;
    logic [BYTE_W-1:0] out_second;
    logic [1:0]        byte_count;
    logic              run_last;
    logic              row_done;
  } out_t;

  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] data;
    logic              finish;
    logic              row_done;
  } pack_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_CLOSE,
    ST_FLUSH_CODE,
    ST_FLUSH_DATA,
    ST_REP_CODE,
    ST_REP_BYTE,
    ST_FINISH
  } state_t;

endpackage

// ----- hw/rtl/pbr_ram.sv -----
// generic single-write, single-read ram with registered read data
module pbr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 80,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/pbr_pack.sv -----
// packs encoded bytes two per output word (one in a final partial word) and holds the output register
module pbr_pack (
  input  logic              clk,
  input  logic              rst,
  input  pbr_pkg::pack_cmd_t cmd,
  output logic              ready,
  output logic              valid,
  input  logic              stall,
  output pbr_pkg::out_t     word
);

  logic [1:0]                 cnt, cnt_next;
  logic [pbr_pkg::BYTE_W-1:0] buf0, buf0_next;
  logic [pbr_pkg::BYTE_W-1:0] buf1, buf1_next;
  logic                       can_push, need_push, push;
  pbr_pkg::out_t              push_word;

  always_comb begin
    can_push  = !valid || !stall;
    need_push = (cmd.emit && cnt == 2'd2) || (cmd.finish && cnt != 2'd0);
    ready     = !need_push || can_push;
    push      = need_push && can_push;
    cnt_next  = cnt;
    buf0_next = buf0;
    buf1_next = buf1;
    if (cmd.finish) begin
      push_word.out_first  = buf0;
      push_word.out_second = (cnt == 2'd2) ? buf1 : '0;
      push_word.byte_count = cnt;
      push_word.run_last   = 1'b1;
      push_word.row_done   = cmd.row_done;
    end else begin
      push_word.out_first  = buf0;
      push_word.out_second = buf1;
      push_word.byte_count = 2'd2;
      push_word.run_last   = 1'b0;
      push_word.row_done   = 1'b0;
    end
    if (ready && cmd.emit) begin
      if (cnt == 2'd1) begin
        buf1_next = cmd.data;
        cnt_next  = 2'd2;
      end else begin
        buf0_next = cmd.data;
        cnt_next  = 2'd1;
      end
    end else if (ready && cmd.finish) begin
      cnt_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= 2'd0;
      valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        valid <= 1'b1;
      end else if (!stall) begin
        valid <= 1'b0;
      end
    end
    buf0 <= buf0_next;
    buf1 <= buf1_next;
    if (push) begin
      word <= push_word;
    end
  end

endmodule

// ----- hw/rtl/packbits_row_encoder.sv -----
// packbits row encoder top level: run/literal sequencer around the literal ram
//
//   channel | handshake              | payload
//   item    | item_valid, item_stall | item (two plane bytes, row end)
//   code    | code_valid, code_stall | code (one or two encoded bytes, flags)
//
// an item steps through accept, a take per byte and finish when no group closes;
// each closed run adds control steps and an emit per encoded byte. The sequencer
// emits one byte a cycle unless stalled, literals from the single ram read port.
// rst is synchronous and clears the run and literal counts, no clearing pass.
// code_stall holds the output register and stalls the sequencer once a word (full or
// final partial) waits to be pushed; item_stall is high while an item is encoded.
module packbits_row_encoder #(
  parameter int ROW_BYTES = 80
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  pbr_pkg::in_t  item,
  output logic          code_valid,
  input  logic          code_stall,
  output pbr_pkg::out_t code
);

  localparam int AW = $clog2(ROW_BYTES);
  localparam int CW = $clog2(ROW_BYTES + 1);

  pbr_pkg::state_t            state, state_next;
  pbr_pkg::in_t               held;
  logic                       byte_sel, byte_sel_next;
  logic                       take_done, take_done_next;
  logic [pbr_pkg::BYTE_W-1:0] pend_byte, pend_byte_next;
  logic [CW-1:0]              pend_cnt, pend_cnt_next;
  logic [CW-1:0]              lit_cnt, lit_cnt_next;
  logic [AW-1:0]              rd_idx, rd_idx_next;
  logic [pbr_pkg::BYTE_W-1:0] cur;
  logic                       advance;
  logic                       last;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [pbr_pkg::BYTE_W-1:0] wr_data, rd_data;
  pbr_pkg::pack_cmd_t         cmd;
  logic                       pack_ready;

  assign item_stall = (state != pbr_pkg::ST_IDLE);

  pbr_ram #(
    .WIDTH (pbr_pkg::BYTE_W),
    .DEPTH (ROW_BYTES),
    .ADDR_W(AW)
  ) u_lit_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  pbr_pack u_pack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .ready(pack_ready),
    .valid(code_valid),
    .stall(code_stall),
    .word (code)
  );

  always_comb begin
    state_next     = state;
    byte_sel_next  = byte_sel;
    take_done_next = take_done;
    pend_byte_next = pend_byte;
    pend_cnt_next  = pend_cnt;
    lit_cnt_next   = lit_cnt;
    rd_idx_next    = rd_idx;
    cur            = byte_sel ? held.second_byte : held.first_byte;
    advance        = 1'b0;
    last           = (CW'(rd_idx) == lit_cnt - CW'(1));
    wr_en          = 1'b0;
    wr_addr        = lit_cnt[AW-1:0];
    wr_data        = pend_byte;
    rd_addr        = rd_idx;
    cmd            = '0;
    cmd.row_done   = held.row_end;

    case (state)
      pbr_pkg::ST_IDLE: begin
        if (item_valid) begin
          byte_sel_next  = 1'b0;
          take_done_next = 1'b0;
          state_next     = pbr_pkg::ST_TAKE;
        end
      end
      pbr_pkg::ST_TAKE: begin
        if (pend_cnt == '0) begin
          pend_byte_next = cur;
          pend_cnt_next  = CW'(1);
          advance        = 1'b1;
        end else if (cur == pend_byte && pend_cnt < CW'(ROW_BYTES)) begin
          pend_cnt_next = pend_cnt + CW'(1);
          advance       = 1'b1;
        end else begin
          state_next = pbr_pkg::ST_CLOSE;
        end
      end
      pbr_pkg::ST_CLOSE: begin
        if (pend_cnt >= CW'(2)) begin
          state_next = (lit_cnt != '0) ? pbr_pkg::ST_FLUSH_CODE : pbr_pkg::ST_REP_CODE;
        end else if (pend_cnt == CW'(1)) begin
          if (lit_cnt >= CW'(ROW_BYTES)) begin
            state_next = pbr_pkg::ST_FLUSH_CODE;
          end else begin
            wr_en         = 1'b1;
            lit_cnt_next  = lit_cnt + CW'(1);
            pend_cnt_next = '0;
          end
        end else if (!take_done) begin
          pend_byte_next = cur;
          pend_cnt_next  = CW'(1);
          advance        = 1'b1;
        end else begin
          state_next = (lit_cnt != '0) ? pbr_pkg::ST_FLUSH_CODE : pbr_pkg::ST_FINISH;
        end
      end
      pbr_pkg::ST_FLUSH_CODE: begin
        cmd.emit = 1'b1;
        cmd.data = pbr_pkg::BYTE_W'(lit_cnt - CW'(1));
        rd_addr  = '0;
        if (pack_ready) begin
          rd_idx_next = '0;
          state_next  = pbr_pkg::ST_FLUSH_DATA;
        end
      end
      pbr_pkg::ST_FLUSH_DATA: begin
        cmd.emit = 1'b1;
        cmd.data = rd_data;
        if (pack_ready) begin
          if (last) begin
            lit_cnt_next = '0;
            state_next   = pbr_pkg::ST_CLOSE;
          end else begin
            rd_idx_next = rd_idx + AW'(1);
            rd_addr     = rd_idx + AW'(1);
          end
        end
      end
      pbr_pkg::ST_REP_CODE: begin
        cmd.emit = 1'b1;
        cmd.data = pbr_pkg::BYTE_W'(pbr_pkg::REP_BASE - 9'(pend_cnt));
        if (pack_ready) begin
          state_next = pbr_pkg::ST_REP_BYTE;
        end
      end
      pbr_pkg::ST_REP_BYTE: begin
        cmd.emit = 1'b1;
        cmd.data = pend_byte;
        if (pack_ready) begin
          pend_cnt_next = '0;
          state_next    = pbr_pkg::ST_CLOSE;
        end
      end
      pbr_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        if (pack_ready) begin
          state_next = pbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pbr_pkg::ST_IDLE;
      end
    endcase

    // move on to the second byte, or to row end / finish after it
    if (advance) begin
      if (!byte_sel) begin
        byte_sel_next = 1'b1;
        state_next    = pbr_pkg::ST_TAKE;
      end else begin
        take_done_next = 1'b1;
        state_next     = held.row_end ? pbr_pkg::ST_CLOSE : pbr_pkg::ST_FINISH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pbr_pkg::ST_IDLE;
      byte_sel  <= 1'b0;
      take_done <= 1'b0;
      pend_byte <= '0;
      pend_cnt  <= '0;
      lit_cnt   <= '0;
      rd_idx    <= '0;
    end else begin
      state     <= state_next;
      byte_sel  <= byte_sel_next;
      take_done <= take_done_next;
      pend_byte <= pend_byte_next;
      pend_cnt  <= pend_cnt_next;
      lit_cnt   <= lit_cnt_next;
      rd_idx    <= rd_idx_next;
    end
    if (state == pbr_pkg::ST_IDLE && item_valid) begin
      held <= item;
    end
  end

  a_lit_bound: assert property (@(posedge clk) disable iff (rst)
    lit_cnt <= CW'(ROW_BYTES))
    else $error("literal count above row length");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    pend_cnt <= CW'(ROW_BYTES))
    else $error("run length above row length");

  a_read_written: assert property (@(posedge clk) disable iff (rst)
    state == pbr_pkg::ST_FLUSH_DATA |-> CW'(rd_idx) < lit_cnt)
    else $error("literal read beyond written entries");

  a_row_clean: assert property (@(posedge clk) disable iff (rst)
    (state == pbr_pkg::ST_FINISH && take_done && held.row_end) |->
      (pend_cnt == '0 && lit_cnt == '0))
    else $error("row finished with run or literals left");

  a_no_write_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state == pbr_pkg::ST_FLUSH_CODE || state == pbr_pkg::ST_FLUSH_DATA) |=>
      $stable(lit_cnt) || lit_cnt == '0)
    else $error("literal count moved during flush");

endmodule
